FILE: rtl/wpm_pkg.sv
`timescale 1ns / 1ps

package wpm_pkg;

   // Number of pattern positions, and with it the number of cells in the row.
   localparam int PATTERN_MAX = 64;
   localparam int SEL_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   localparam int SYM_W = 8;
   localparam int IDX_W = 6;
   localparam int OP_W  = 2;
   localparam int LEN_W = 7;
   localparam int POS_W = 32;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;

   localparam logic [SYM_W-1:0] WILDCARD = 8'd63;
   localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};

   localparam logic [OP_W-1:0] OP_LOAD       = 2'd0;
   localparam logic [OP_W-1:0] OP_TEXT_FIRST = 2'd1;
   localparam logic [OP_W-1:0] OP_TEXT_NEXT  = 2'd2;

   typedef enum logic {
      ST_RUN,
      ST_REPLAY
   } state_type;

   // What one cell hands to the next: its window byte, whether that byte belongs
   // to the current text, and whether the pattern prefix ending here matched.
   typedef struct packed {
      logic [SYM_W-1:0] sym;
      logic             vld;
      logic             hit;
      logic             head;
   } link_type;

   // Signals driven to every cell alike.
   typedef struct packed {
      logic [SYM_W-1:0] sym;
      logic             sym_vld;
      logic             shift;
      logic             clear;
      logic [SYM_W-1:0] pat_sym;
   } bcast_type;

endpackage

FILE: rtl/wpm_cell.sv
`timescale 1ns / 1ps

module wpm_cell (
   input  logic                clock,
   input  logic                reset,
   input  wpm_pkg::bcast_type  bcast,
   input  logic                pat_we,
   input  wpm_pkg::link_type   link_prev,
   output wpm_pkg::link_type   link_next,
   output logic                hit_next
);

   logic [wpm_pkg::SYM_W-1:0] pat_ff;
   logic [wpm_pkg::SYM_W-1:0] sym_ff;
   logic [wpm_pkg::SYM_W-1:0] sym_in;
   logic                      vld_ff;
   logic                      vld_in;
   logic                      hit_ff;
   logic                      hit_in;
   logic                      keep;
   logic                      sym_eq;

   // A new text drops everything behind the first cell.
   always_comb begin
      keep   = link_prev.head | ~bcast.clear;
      sym_eq = (pat_ff == bcast.sym) | (pat_ff == wpm_pkg::WILDCARD);
      hit_in = link_prev.hit & keep & bcast.sym_vld & sym_eq;
      vld_in = link_prev.vld & keep;
      sym_in = link_prev.sym;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else if (bcast.shift) begin
         vld_ff <= vld_in;
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bcast.shift) begin
         sym_ff <= sym_in;
      end
      if (pat_we) begin
         pat_ff <= bcast.pat_sym;
      end
   end

   assign link_next.sym  = sym_ff;
   assign link_next.vld  = vld_ff;
   assign link_next.hit  = hit_ff;
   assign link_next.head = 1'b0;
   assign hit_next       = hit_in;

endmodule

FILE: rtl/wildcard_pattern_matcher.sv
`timescale 1ns / 1ps

// Streaming matcher of a stored pattern, where the pattern byte '?' matches any byte.
// Requests enter on req_*: req_tuser carries the operation (load pattern byte,
// first byte of a new text, next text byte) and req_tdata the index and symbol.
// Each text request gives one response on rsp_*: a match flag and the start
// position of the matching window; loads give none. csr_* sets the pattern length.
// The pattern sits in a row of cells, one per position. Each cell keeps one window
// byte and a flag telling whether the pattern prefix ending at it matched; the
// flags move one cell along per text byte, so while no rebuild runs and the output
// is free a request is taken every cycle, its response registered on acceptance.
// A response waits in that register while rsp_tready is low; a new request is
// taken in the same cycle that the waiting response leaves.
// When pattern bytes are loaded in the middle of a text, the next text byte waits
// while the state machine enters replay and the window is rotated once through
// the row to rebuild the flags.
// Reset leaves an empty window, position zero and length one; pattern contents
// are undefined until loaded.
module wildcard_pattern_matcher (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [5:0] pattern_index, [13:6] symbol, [15:14] zero
   input  logic [wpm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] operation
   input  logic [wpm_pkg::OP_W-1:0]         req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] match_found, [32:1] match_start, [39:33] zero
   output logic [wpm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [wpm_pkg::LEN_W-1:0]        csr_wdata
);

   localparam int NCELL = wpm_pkg::PATTERN_MAX;
   localparam int SEL_W = wpm_pkg::SEL_W;
   localparam int POS_W = wpm_pkg::POS_W;

   wpm_pkg::state_type state_ff, state_in;
   logic [SEL_W-1:0]   cnt_ff, cnt_in;
   logic               dirty_ff, dirty_in;
   logic [wpm_pkg::LEN_W-1:0] len_ff;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [POS_W-1:0]   rsp_start_ff, rsp_start_in;

   logic [wpm_pkg::OP_W-1:0]  op;
   logic [wpm_pkg::IDX_W-1:0] idx;
   logic [wpm_pkg::SYM_W-1:0] sym;
   logic               is_text;
   logic               need_replay;
   logic               out_free;
   logic               in_run;
   logic               replay_step;
   logic               replay_last;
   logic               acc;
   logic [SEL_W-1:0]   eff_m1;
   logic [POS_W-1:0]   here;
   logic               hit_sel;

   wpm_pkg::bcast_type bcast;
   wpm_pkg::link_type  links [NCELL+1];
   logic [NCELL-1:0]   hit_next;
   logic [NCELL-1:0]   pat_we;

   assign op  = req_tuser;
   assign idx = req_tdata[wpm_pkg::IDX_W-1:0];
   assign sym = req_tdata[wpm_pkg::IDX_W +: wpm_pkg::SYM_W];

   always_comb begin
      is_text     = (op == wpm_pkg::OP_TEXT_FIRST) || (op == wpm_pkg::OP_TEXT_NEXT);
      need_replay = req_tvalid && (op == wpm_pkg::OP_TEXT_NEXT) && dirty_ff
                    && links[1].vld;
      out_free    = !rsp_valid_ff || rsp_tready;
      replay_last = (cnt_ff == SEL_W'(NCELL - 1));
   end

   // State machine: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wpm_pkg::ST_RUN: begin
            if (need_replay) begin
               state_in = wpm_pkg::ST_REPLAY;
            end
         end
         wpm_pkg::ST_REPLAY: begin
            if (replay_last) begin
               state_in = wpm_pkg::ST_RUN;
            end
         end
         default: state_in = wpm_pkg::ST_RUN;
      endcase
   end

   // State machine: outputs.
   always_comb begin
      in_run      = 1'b0;
      replay_step = 1'b0;
      unique case (state_ff)
         wpm_pkg::ST_RUN:    in_run = 1'b1;
         wpm_pkg::ST_REPLAY: replay_step = 1'b1;
         default:            in_run = 1'b0;
      endcase
   end

   assign req_tready = in_run && out_free && !need_replay;
   assign acc        = req_tvalid && req_tready;

   // During a replay the oldest window byte comes back round into the first cell.
   always_comb begin
      bcast.sym     = replay_step ? links[NCELL].sym : sym;
      bcast.sym_vld = replay_step ? links[NCELL].vld : 1'b1;
      bcast.shift   = replay_step || (acc && is_text);
      bcast.clear   = !replay_step && (op == wpm_pkg::OP_TEXT_FIRST);
      bcast.pat_sym = sym;
      links[0].sym  = bcast.sym;
      links[0].vld  = bcast.sym_vld;
      links[0].hit  = 1'b1;
      links[0].head = 1'b1;
   end

   for (genvar j = 0; j < NCELL; j++) begin : g_cell
      assign pat_we[j] = acc && (op == wpm_pkg::OP_LOAD)
                         && (idx == wpm_pkg::IDX_W'(j));
      wpm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .bcast     (bcast),
         .pat_we    (pat_we[j]),
         .link_prev (links[j]),
         .link_next (links[j+1]),
         .hit_next  (hit_next[j])
      );
   end

   // A length of zero acts as one, and one beyond the row as the whole row.
   always_comb begin
      if (len_ff == '0) begin
         eff_m1 = '0;
      end else if (len_ff > wpm_pkg::LEN_W'(NCELL)) begin
         eff_m1 = SEL_W'(NCELL - 1);
      end else begin
         eff_m1 = SEL_W'(len_ff - 1'b1);
      end
   end

   always_comb begin
      here         = (op == wpm_pkg::OP_TEXT_FIRST) ? '0 : pos_ff;
      pos_in       = (here == wpm_pkg::POS_MAX) ? here : here + 1'b1;
      hit_sel      = hit_next[eff_m1];
      rsp_hit_in   = hit_sel;
      rsp_start_in = hit_sel ? here - POS_W'(eff_m1) : '0;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (replay_step) begin
         cnt_in = replay_last ? '0 : cnt_ff + 1'b1;
      end
   end

   always_comb begin
      dirty_in = dirty_ff;
      if (replay_step && replay_last) begin
         dirty_in = 1'b0;
      end else if (acc && op == wpm_pkg::OP_TEXT_FIRST) begin
         dirty_in = 1'b0;
      end else if (acc && op == wpm_pkg::OP_LOAD && links[1].vld) begin
         dirty_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (acc && is_text) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wpm_pkg::ST_RUN;
         cnt_ff       <= '0;
         dirty_ff     <= 1'b0;
         len_ff       <= wpm_pkg::LEN_W'(1);
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            len_ff <= csr_wdata;
         end
         if (acc && is_text) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc && is_text) begin
         rsp_hit_ff   <= rsp_hit_in;
         rsp_start_ff <= rsp_start_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(wpm_pkg::RSP_DATA_W - POS_W - 1){1'b0}}, rsp_start_ff, rsp_hit_ff};

`ifndef SYNTHESIS
   a_no_req_in_replay: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wpm_pkg::ST_REPLAY) |-> !req_tready)
      else $error("request taken during window replay");

   a_replay_clears_dirty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wpm_pkg::ST_REPLAY && replay_last) |=> !dirty_ff)
      else $error("pattern still marked changed after replay");

   a_cnt_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wpm_pkg::ST_RUN) |-> (cnt_ff == '0))
      else $error("replay counter not at zero outside replay");

   a_hit_needs_length: assert property (@(posedge clock) disable iff (reset)
      (acc && is_text && hit_sel) |-> (here >= POS_W'(eff_m1)))
      else $error("match reported before enough text arrived");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_start_ff)))
      else $error("stalled response lost or changed");
`endif

endmodule

FILE: verif/tb_wildcard_pattern_matcher.sv
`timescale 1ns / 1ps

module tb_wildcard_pattern_matcher;

   localparam logic [wpm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   // Long enough for the window rebuild that follows pattern loads in mid-text.
   localparam int SETTLE_CYCLES = 80;
   localparam int STALL_LIMIT   = 3000;
   localparam int MAX_REPORTS   = 10;
   localparam int HOLD_CYCLES   = 300;

   localparam logic [wpm_pkg::SYM_W-1:0] SYM_A = 8'h61;
   localparam logic [wpm_pkg::SYM_W-1:0] SYM_B = 8'h62;
   localparam logic [wpm_pkg::SYM_W-1:0] SYM_C = 8'h63;

   typedef struct packed {
      logic                      found;
      logic [wpm_pkg::POS_W-1:0] start;
   } match_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [wpm_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [wpm_pkg::OP_W-1:0]       req_tuser  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [wpm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_we     = 1'b0;
   logic [wpm_pkg::LEN_W-1:0]      csr_wdata  = '0;

   // Predicted state of the matcher.
   logic [wpm_pkg::SYM_W-1:0] pat_mem [wpm_pkg::PATTERN_MAX];
   logic [wpm_pkg::SYM_W-1:0] win     [wpm_pkg::PATTERN_MAX];
   logic [wpm_pkg::POS_W-1:0] txt_pos;
   logic [wpm_pkg::LEN_W-1:0] pat_len;
   match_type                 expected_matches[$];

   int send_idle_pct = 9;
   int recv_idle_pct = 61;
   int hold_left     = 0;
   int items_sent    = 0;
   int error_count   = 0;
   int idle_cycles   = 0;

   wildcard_pattern_matcher i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int eff_len();
      if (pat_len == 0) return 1;
      if (pat_len > wpm_pkg::PATTERN_MAX) return wpm_pkg::PATTERN_MAX;
      return int'(pat_len);
   endfunction

   function automatic void predict_request(input logic [wpm_pkg::OP_W-1:0] op,
                                           input logic [wpm_pkg::IDX_W-1:0] idx,
                                           input logic [wpm_pkg::SYM_W-1:0] sym);
      int                        len;
      logic [wpm_pkg::POS_W-1:0] here;
      logic                      hit;
      match_type                 m;
      if (op == wpm_pkg::OP_LOAD) begin
         pat_mem[idx] = sym;
         return;
      end
      if (op == OP_UNUSED) return;
      if (op == wpm_pkg::OP_TEXT_FIRST) begin
         foreach (win[i]) win[i] = '0;
         txt_pos = '0;
      end
      for (int i = wpm_pkg::PATTERN_MAX - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = sym;
      here = txt_pos;
      if (txt_pos != wpm_pkg::POS_MAX) txt_pos++;
      len = eff_len();
      // No match is possible until the text holds a full pattern length.
      hit = ({1'b0, here} + 33'd1 >= 33'(len));
      for (int j = 0; j < len; j++)
         if (pat_mem[j] != win[len-1-j] && pat_mem[j] != wpm_pkg::WILDCARD) hit = 1'b0;
      m.found = hit;
      m.start = hit ? here - wpm_pkg::POS_W'(len - 1) : '0;
      expected_matches.insert(expected_matches.size(), m);
   endfunction

   function automatic void report_failure(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%s", msg);
   endfunction

   function automatic logic [wpm_pkg::SYM_W-1:0] text_symbol();
      if ($urandom_range(99) < 70) return SYM_A + wpm_pkg::SYM_W'($urandom_range(1));
      return wpm_pkg::SYM_W'($urandom_range(255));
   endfunction

   function automatic logic [wpm_pkg::SYM_W-1:0] pattern_symbol();
      int r;
      r = $urandom_range(99);
      if (r < 30) return wpm_pkg::WILDCARD;
      if (r < 75) return SYM_A + wpm_pkg::SYM_W'($urandom_range(1));
      return wpm_pkg::SYM_W'($urandom_range(255));
   endfunction

   function automatic logic [wpm_pkg::LEN_W-1:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 45) return wpm_pkg::LEN_W'($urandom_range(6, 1));
      if (r < 53) return '0;
      if (r < 61) return wpm_pkg::LEN_W'(wpm_pkg::PATTERN_MAX);
      if (r < 67) return '1;
      if (r < 72) return wpm_pkg::LEN_W'($urandom_range(126, 65));
      return wpm_pkg::LEN_W'($urandom_range(63, 7));
   endfunction

   // Called just after a falling edge; returns at the falling edge after the
   // request was taken, with tvalid still high.
   task automatic send_request(input logic [wpm_pkg::OP_W-1:0] op,
                               input logic [wpm_pkg::IDX_W-1:0] idx,
                               input logic [wpm_pkg::SYM_W-1:0] sym);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, sym, idx};
      do @(posedge clock); while (!req_tready);
      predict_request(op, idx, sym);
      if (op != OP_UNUSED) items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      while (expected_matches.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_length(input logic [wpm_pkg::LEN_W-1:0] value);
      wait_results_done();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      pat_len    = value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Sends the pattern with each wildcard replaced by a random byte.
   task automatic send_pattern_copy();
      for (int j = 0; j < eff_len(); j++)
         send_request(wpm_pkg::OP_TEXT_NEXT, wpm_pkg::IDX_W'($urandom_range(63)),
                      (pat_mem[j] == wpm_pkg::WILDCARD) ? text_symbol() : pat_mem[j]);
   endtask

   task automatic send_text(input bit new_text);
      int n;
      int r;
      n = $urandom_range(24, 4);
      if (new_text)
         send_request(wpm_pkg::OP_TEXT_FIRST, wpm_pkg::IDX_W'($urandom_range(63)),
                      text_symbol());
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 30) send_pattern_copy();
         else if (r < 36)
            send_request(wpm_pkg::OP_LOAD, wpm_pkg::IDX_W'($urandom_range(63)),
                         pattern_symbol());
         else if (r < 39)
            send_request(OP_UNUSED, wpm_pkg::IDX_W'($urandom_range(63)),
                         wpm_pkg::SYM_W'($urandom_range(255)));
         else
            send_request(wpm_pkg::OP_TEXT_NEXT, wpm_pkg::IDX_W'($urandom_range(63)),
                         text_symbol());
      end
   endtask

   task automatic test_pattern_fill();
      for (int i = 0; i < wpm_pkg::PATTERN_MAX; i++)
         send_request(wpm_pkg::OP_LOAD, wpm_pkg::IDX_W'(i), pattern_symbol());
   endtask

   task automatic test_directed_cases();
      write_length(wpm_pkg::LEN_W'(3));
      send_request(wpm_pkg::OP_LOAD, 6'd0, SYM_A);
      send_request(wpm_pkg::OP_LOAD, 6'd1, wpm_pkg::WILDCARD);
      send_request(wpm_pkg::OP_LOAD, 6'd2, SYM_C);
      send_request(wpm_pkg::OP_TEXT_FIRST, 6'd0, SYM_A);
      send_request(wpm_pkg::OP_TEXT_NEXT, 6'd0, 8'h00);
      send_request(wpm_pkg::OP_TEXT_NEXT, 6'd0, SYM_C);
      send_request(wpm_pkg::OP_TEXT_NEXT, 6'd63, SYM_A);
      send_request(wpm_pkg::OP_TEXT_NEXT, 6'd63, 8'hFF);
      send_request(wpm_pkg::OP_TEXT_NEXT, 6'd63, SYM_C);
      send_request(OP_UNUSED, 6'd63, 8'hFF);
      send_request(wpm_pkg::OP_LOAD, 6'd63, 8'hFF);
      // Changing the pattern in mid-text forces the window rebuild.
      send_request(wpm_pkg::OP_LOAD, 6'd1, SYM_B);
      send_request(wpm_pkg::OP_TEXT_NEXT, 6'd0, SYM_A);
      send_request(wpm_pkg::OP_TEXT_NEXT, 6'd0, SYM_B);
      send_request(wpm_pkg::OP_TEXT_NEXT, 6'd0, SYM_C);
      send_request(wpm_pkg::OP_TEXT_NEXT, 6'd0, SYM_A);
      send_request(wpm_pkg::OP_TEXT_NEXT, 6'd0, SYM_B);
      // A stale window would complete the pattern here; a new text must not.
      send_request(wpm_pkg::OP_TEXT_FIRST, 6'd0, SYM_C);
      write_length('0);
      send_request(wpm_pkg::OP_TEXT_FIRST, 6'd0, SYM_A);
      send_request(wpm_pkg::OP_TEXT_NEXT, 6'd0, 8'h00);
      write_length('1);
      send_request(wpm_pkg::OP_TEXT_FIRST, 6'd0, SYM_A);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait_results_done();
      hold_left = HOLD_CYCLES;
      send_request(wpm_pkg::OP_TEXT_FIRST, 6'd0, text_symbol());
      repeat (23) send_request(wpm_pkg::OP_TEXT_NEXT, 6'd0, text_symbol());
      wait_results_done();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
      int stop;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop = items_sent + count;
      while (items_sent < stop) begin
         if ($urandom_range(99) < 15) begin
            write_length(pick_length());
            if ($urandom_range(1))
               for (int j = 0; j < eff_len(); j++)
                  send_request(wpm_pkg::OP_LOAD, wpm_pkg::IDX_W'(j), pattern_symbol());
            send_text($urandom_range(99) < 80);
         end else begin
            send_text($urandom_range(99) < 70);
         end
      end
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_responses
      match_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_matches.size() == 0) begin
            report_failure($sformatf("unexpected response: data %h", rsp_tdata));
         end else begin
            want = expected_matches.pop_front();
            if (rsp_tdata[0] !== want.found || rsp_tdata[32:1] !== want.start)
               report_failure($sformatf(
                  "match mismatch: expected found %0b start %0d, got found %0b start %0d",
                  want.found, want.start, rsp_tdata[0], rsp_tdata[32:1]));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      foreach (pat_mem[i]) pat_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      txt_pos = '0;
      pat_len = wpm_pkg::LEN_W'(1);
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_pattern_fill();
      test_directed_cases();
      test_random_traffic(9, 61, 100);
      test_random_traffic(61, 9, 100);
      test_random_traffic(0, 0, 100);
      test_backpressure();
      wait_results_done();
      if (error_count == 0 && expected_matches.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
